// File: sv/ec2c_pkg.sv
// ----------------------------------------------------------------------------
// ec2c_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ec2c_pkg;

  // widths of the transfer fields
  localparam int unsigned EPOCH_W  = 31;
  localparam int unsigned YEAR_W   = 11;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned ZONE_W   = 4;

  // day count after the hour split stays below 2^15
  localparam int unsigned DAYS_W   = 15;
  // product of the reciprocal multiplier
  localparam int unsigned MUL_X_W  = 29;
  localparam int unsigned MUL_M_W  = 32;
  localparam int unsigned PROD_W   = MUL_X_W + MUL_M_W;
  localparam int unsigned RECIP_SH = 33;

  // reciprocals rounded up, 2^33/15 and 2^33/3
  localparam logic [MUL_M_W-1:0] RECIP_15 = 32'd572662307;
  localparam logic [MUL_M_W-1:0] RECIP_3  = 32'd2863311531;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 4'd8;
  localparam logic [YEAR_W-1:0] BASE_YEAR  = 11'd1970;
  // base year position in the 100 and 400 year cycles
  localparam logic [6:0]        BASE_Y100  = 7'd70;
  localparam logic [8:0]        BASE_Y400  = 9'd370;
  localparam logic [6:0]        LAST_Y100  = 7'd99;
  localparam logic [8:0]        LAST_Y400  = 9'd399;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SEC,
    ST_DIV_SEC,
    ST_MUL_MIN,
    ST_DIV_MIN,
    ST_MUL_HR,
    ST_DIV_HR,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_SEC,
    OP_DIV_SEC,
    OP_MUL_MIN,
    OP_DIV_MIN,
    OP_MUL_HR,
    OP_DIV_HR,
    OP_YEAR,
    OP_MONTH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_stop;
  } dp_status_t;

  // days in a month, month counted from 0
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: sv/ec2c_ctrl.sv
// ----------------------------------------------------------------------------
// ec2c_ctrl
// Sequencer: steps the datapath through the three splits, the year walk and
// the month walk, then strobes the result.
// ----------------------------------------------------------------------------
module ec2c_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  ec2c_pkg::dp_status_t   status,
  output ec2c_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   done
);

  ec2c_pkg::state_t state;
  ec2c_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ec2c_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ec2c_pkg::ST_IDLE: begin
        if (start) state_next = ec2c_pkg::ST_MUL_SEC;
      end
      ec2c_pkg::ST_MUL_SEC: state_next = ec2c_pkg::ST_DIV_SEC;
      ec2c_pkg::ST_DIV_SEC: state_next = ec2c_pkg::ST_MUL_MIN;
      ec2c_pkg::ST_MUL_MIN: state_next = ec2c_pkg::ST_DIV_MIN;
      ec2c_pkg::ST_DIV_MIN: state_next = ec2c_pkg::ST_MUL_HR;
      ec2c_pkg::ST_MUL_HR:  state_next = ec2c_pkg::ST_DIV_HR;
      ec2c_pkg::ST_DIV_HR:  state_next = ec2c_pkg::ST_YEAR;
      ec2c_pkg::ST_YEAR: begin
        if (status.year_fits) state_next = ec2c_pkg::ST_MONTH;
      end
      ec2c_pkg::ST_MONTH: begin
        if (status.month_stop) state_next = ec2c_pkg::ST_DONE;
      end
      ec2c_pkg::ST_DONE: state_next = ec2c_pkg::ST_IDLE;
      default:            state_next = ec2c_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op = ec2c_pkg::OP_NONE;
    busy   = 1'b1;
    done   = 1'b0;
    case (state)
      ec2c_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) cmd.op = ec2c_pkg::OP_LOAD;
      end
      ec2c_pkg::ST_MUL_SEC: cmd.op = ec2c_pkg::OP_MUL_SEC;
      ec2c_pkg::ST_DIV_SEC: cmd.op = ec2c_pkg::OP_DIV_SEC;
      ec2c_pkg::ST_MUL_MIN: cmd.op = ec2c_pkg::OP_MUL_MIN;
      ec2c_pkg::ST_DIV_MIN: cmd.op = ec2c_pkg::OP_DIV_MIN;
      ec2c_pkg::ST_MUL_HR:  cmd.op = ec2c_pkg::OP_MUL_HR;
      ec2c_pkg::ST_DIV_HR:  cmd.op = ec2c_pkg::OP_DIV_HR;
      ec2c_pkg::ST_YEAR:    cmd.op = ec2c_pkg::OP_YEAR;
      ec2c_pkg::ST_MONTH:   cmd.op = ec2c_pkg::OP_MONTH;
      ec2c_pkg::ST_DONE:    done   = 1'b1;
      default:              busy   = 1'b0;
    endcase
  end

endmodule

// File: sv/ec2c_dp.sv
// ----------------------------------------------------------------------------
// ec2c_dp
// Datapath: reciprocal multiplier for the splits by 60, 60 and 24, the zone
// register, the year and month subtractors and the result registers.
// ----------------------------------------------------------------------------
module ec2c_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ec2c_pkg::ZONE_W-1:0]      cfg_wr_data,
  input  logic [ec2c_pkg::EPOCH_W-1:0]     epoch_seconds,
  input  ec2c_pkg::dp_cmd_t                cmd,
  output ec2c_pkg::dp_status_t             status,
  output logic [ec2c_pkg::YEAR_W-1:0]      year,
  output logic [ec2c_pkg::MONTH_W-1:0]     month,
  output logic [ec2c_pkg::DAY_W-1:0]       day,
  output logic [ec2c_pkg::HOUR_W-1:0]      hour,
  output logic [ec2c_pkg::MINUTE_W-1:0]    minute,
  output logic [ec2c_pkg::SECOND_W-1:0]    second
);

  logic [ec2c_pkg::ZONE_W-1:0]   zone;
  logic [ec2c_pkg::EPOCH_W-1:0]  acc;
  logic [ec2c_pkg::PROD_W-1:0]   prod;
  logic [ec2c_pkg::DAYS_W-1:0]   days;
  logic [ec2c_pkg::YEAR_W-1:0]   yr;
  logic [6:0]                    y100;
  logic [8:0]                    y400;
  logic [ec2c_pkg::MONTH_W-1:0]  mon;
  logic [ec2c_pkg::HOUR_W-1:0]   hr;
  logic [ec2c_pkg::MINUTE_W-1:0] mins;
  logic [ec2c_pkg::SECOND_W-1:0] secs;

  logic [ec2c_pkg::MUL_X_W-1:0]  mul_x;
  logic [ec2c_pkg::MUL_M_W-1:0]  mul_m;
  logic [ec2c_pkg::EPOCH_W-1:0]  quot;
  logic [ec2c_pkg::EPOCH_W-1:0]  rem60;
  logic [ec2c_pkg::EPOCH_W-1:0]  rem24;
  logic                          leap;
  logic [8:0]                    ylen;
  logic [ec2c_pkg::DAY_W-1:0]    mlen;

  // zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ec2c_pkg::ZONE_RESET;
    end else if (cfg_wr_en) begin
      zone <= cfg_wr_data;
    end
  end

  // multiplier operands: by 60 is by 4 then 15, by 24 is by 8 then 3
  always_comb begin
    if (cmd.op == ec2c_pkg::OP_MUL_HR) begin
      mul_x = ec2c_pkg::MUL_X_W'(acc[ec2c_pkg::EPOCH_W-1:3]);
      mul_m = ec2c_pkg::RECIP_3;
    end else begin
      mul_x = acc[ec2c_pkg::EPOCH_W-1:2];
      mul_m = ec2c_pkg::RECIP_15;
    end
  end

  // quotient and remainders from the registered product
  assign quot  = ec2c_pkg::EPOCH_W'(prod[ec2c_pkg::PROD_W-1:ec2c_pkg::RECIP_SH]);
  assign rem60 = acc - ((quot << 6) - (quot << 2));
  assign rem24 = acc - ((quot << 5) - (quot << 3));

  // leap year from the cycle positions
  assign leap = (y400 == 9'd0) || ((y100 != 7'd0) && (yr[1:0] == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = ec2c_pkg::month_len(mon, leap);

  assign status.year_fits  = (days < ec2c_pkg::DAYS_W'(ylen));
  assign status.month_stop = (mon == ec2c_pkg::LAST_MONTH) ||
                             (days < ec2c_pkg::DAYS_W'(mlen));

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ec2c_pkg::OP_LOAD: begin
        acc <= epoch_seconds;
      end
      ec2c_pkg::OP_MUL_SEC, ec2c_pkg::OP_MUL_MIN, ec2c_pkg::OP_MUL_HR: begin
        prod <= ec2c_pkg::PROD_W'(mul_x) * ec2c_pkg::PROD_W'(mul_m);
      end
      ec2c_pkg::OP_DIV_SEC: begin
        secs <= rem60[ec2c_pkg::SECOND_W-1:0];
        acc  <= quot;
      end
      ec2c_pkg::OP_DIV_MIN: begin
        mins <= rem60[ec2c_pkg::MINUTE_W-1:0];
        acc  <= quot + ec2c_pkg::EPOCH_W'(zone);
      end
      ec2c_pkg::OP_DIV_HR: begin
        hr   <= rem24[ec2c_pkg::HOUR_W-1:0];
        days <= quot[ec2c_pkg::DAYS_W-1:0];
        yr   <= ec2c_pkg::BASE_YEAR;
        y100 <= ec2c_pkg::BASE_Y100;
        y400 <= ec2c_pkg::BASE_Y400;
        mon  <= '0;
      end
      ec2c_pkg::OP_YEAR: begin
        if (!status.year_fits) begin
          days <= days - ec2c_pkg::DAYS_W'(ylen);
          yr   <= yr + 1'b1;
          y100 <= (y100 == ec2c_pkg::LAST_Y100) ? 7'd0 : y100 + 1'b1;
          y400 <= (y400 == ec2c_pkg::LAST_Y400) ? 9'd0 : y400 + 1'b1;
        end
      end
      ec2c_pkg::OP_MONTH: begin
        if (!status.month_stop) begin
          days <= days - ec2c_pkg::DAYS_W'(mlen);
          mon  <= mon + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result fields
  assign year   = yr;
  assign month  = mon + 1'b1;
  assign day    = days[ec2c_pkg::DAY_W-1:0] + 1'b1;
  assign hour   = hr;
  assign minute = mins;
  assign second = secs;

endmodule

// File: sv/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 into Gregorian date and time of
// day, with a whole-hour zone offset.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | start / busy       | epoch_seconds
//   result   | done (one cycle)   | year, month, day, hour, minute, second
//   config   | cfg_wr_en          | cfg_wr_data (zone offset, reset 8)
//
// After the transfer the sequencer runs a reciprocal multiply and a
// remainder step for each of the splits by 60, 60 and 24, then takes whole
// years off the day count until the year is found, then whole months until
// the month is found, and then strobes done. busy stays high from the
// transfer through the done cycle. Reset clears the sequencer and sets the
// zone offset to 8. The result fields hold after the done cycle until the
// next item rewrites them, and the strobe cannot be held off.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ec2c_pkg::EPOCH_W-1:0]     epoch_seconds,
  input  logic                             cfg_wr_en,
  input  logic [ec2c_pkg::ZONE_W-1:0]      cfg_wr_data,
  output logic                             done,
  output logic [ec2c_pkg::YEAR_W-1:0]      year,
  output logic [ec2c_pkg::MONTH_W-1:0]     month,
  output logic [ec2c_pkg::DAY_W-1:0]       day,
  output logic [ec2c_pkg::HOUR_W-1:0]      hour,
  output logic [ec2c_pkg::MINUTE_W-1:0]    minute,
  output logic [ec2c_pkg::SECOND_W-1:0]    second
);

  ec2c_pkg::dp_cmd_t    cmd;
  ec2c_pkg::dp_status_t status;

  // sequencer
  ec2c_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // arithmetic and result registers
  ec2c_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .epoch_seconds (epoch_seconds),
    .cmd           (cmd),
    .status        (status),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule

// File: sv/ec2c_checker.sv
// ----------------------------------------------------------------------------
// ec2c_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ec2c_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [ec2c_pkg::MONTH_W-1:0]     month,
  input logic [ec2c_pkg::DAY_W-1:0]       day,
  input logic [ec2c_pkg::HOUR_W-1:0]      hour,
  input logic [ec2c_pkg::MINUTE_W-1:0]    minute,
  input logic [ec2c_pkg::SECOND_W-1:0]    second
);

  // a transfer makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // the strobe only comes while busy and lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy ##1 !done))
    else $error("done strobe not a single busy cycle");

  // the block is free again right after the strobe
  a_free_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after done");

  // date fields in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1))
    else $error("date field out of range");

  // time of day fields in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_core ec2c_checker u_ec2c_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .month  (month),
  .day    (day),
  .hour   (hour),
  .minute (minute),
  .second (second)
);

// File: tb/epoch_seconds_to_calendar_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core_tb
// Self-checking bench for the epoch seconds to calendar converter. Sends
// directed and random second counts through the start/busy port and works
// out the expected date and time of day for each transfer with its own
// calendar arithmetic. Every done strobe is checked field by field against
// the oldest pending date. The zone offset register is rewritten between
// phases, covering zero, the reset value, the top of range and fifteen.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core_tb;

  localparam int unsigned  CLK_HALF    = 5;
  localparam int unsigned  CYCLE_LIMIT = 1000000;
  localparam int unsigned  TAIL_CYCLES = 100;
  localparam int unsigned  PHASE_ITEMS = 133;
  localparam longint       EPOCH_MAX   = 64'd2147483647;
  localparam int unsigned  SECS_DAY    = 86400;
  localparam int unsigned  SECS_HOUR   = 3600;
  localparam int unsigned  FIRST_YEAR  = 1970;
  localparam int unsigned  LAST_YEAR   = 2038;

  typedef struct {
    logic [ec2c_pkg::YEAR_W-1:0]   year;
    logic [ec2c_pkg::MONTH_W-1:0]  month;
    logic [ec2c_pkg::DAY_W-1:0]    day;
    logic [ec2c_pkg::HOUR_W-1:0]   hour;
    logic [ec2c_pkg::MINUTE_W-1:0] minute;
    logic [ec2c_pkg::SECOND_W-1:0] second;
  } calendar_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [ec2c_pkg::EPOCH_W-1:0]  epoch_seconds;
  logic                          cfg_wr_en;
  logic [ec2c_pkg::ZONE_W-1:0]   cfg_wr_data;
  logic                          done;
  logic [ec2c_pkg::YEAR_W-1:0]   year;
  logic [ec2c_pkg::MONTH_W-1:0]  month;
  logic [ec2c_pkg::DAY_W-1:0]    day;
  logic [ec2c_pkg::HOUR_W-1:0]   hour;
  logic [ec2c_pkg::MINUTE_W-1:0] minute;
  logic [ec2c_pkg::SECOND_W-1:0] second;

  calendar_t                     pending_dates[$];
  logic [ec2c_pkg::ZONE_W-1:0]   zone_model;
  int unsigned                   mismatches;
  int unsigned                   cycle_count;
  int unsigned                   burst_left;
  bit                            gaps_enabled;

  epoch_seconds_to_calendar_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .epoch_seconds (epoch_seconds),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // gregorian leap rule
  function automatic int unsigned is_leap_year(input int unsigned y);
    if (y % 400 == 0) return 1;
    if (y % 100 == 0) return 0;
    return (y % 4 == 0) ? 1 : 0;
  endfunction

  // days in a month counted from 0
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      1:       return 28 + is_leap_year(y);
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // expected date and time of day for one second count
  function automatic calendar_t calendar_of(input logic [ec2c_pkg::EPOCH_W-1:0] secs,
                                            input logic [ec2c_pkg::ZONE_W-1:0] zone);
    calendar_t   r;
    longint unsigned t;
    longint unsigned days;
    int unsigned y;
    int unsigned m;
    int unsigned mlen;
    t        = secs;
    r.second = ec2c_pkg::SECOND_W'(t % 60);
    t        = t / 60;
    r.minute = ec2c_pkg::MINUTE_W'(t % 60);
    t        = t / 60 + zone;
    r.hour   = ec2c_pkg::HOUR_W'(t % 24);
    days     = t / 24;
    // whole years first, then whole months
    y = FIRST_YEAR;
    while (days >= 365 + is_leap_year(y)) begin
      days = days - (365 + is_leap_year(y));
      y++;
    end
    m = 0;
    while (m < 11) begin
      mlen = days_in_month(m, y);
      if (days < mlen) break;
      days = days - mlen;
      m++;
    end
    r.year  = ec2c_pkg::YEAR_W'(y);
    r.month = ec2c_pkg::MONTH_W'(m + 1);
    r.day   = ec2c_pkg::DAY_W'(days + 1);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // track register writes, record transfers and check each strobe
  always @(posedge clk) begin
    calendar_t want;
    if (rst) begin
      zone_model = ec2c_pkg::ZONE_RESET;
    end else begin
      if (cfg_wr_en) zone_model = cfg_wr_data;
      if (start && !busy) pending_dates.push_back(calendar_of(epoch_seconds, zone_model));
      if (done) begin
        if (pending_dates.size() == 0) begin
          $error("result strobe with no pending date");
          mismatches++;
        end else begin
          want = pending_dates.pop_front();
          check_field("year",   want.year,   year);
          check_field("month",  want.month,  month);
          check_field("day",    want.day,    day);
          check_field("hour",   want.hour,   hour);
          check_field("minute", want.minute, minute);
          check_field("second", want.second, second);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one transfer, then the burst and gap pacing of the sender
  task automatic send_seconds(input logic [ec2c_pkg::EPOCH_W-1:0] secs);
    int unsigned gap;
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    if (!gaps_enabled) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap           = $urandom_range(1, 15);
      burst_left    = $urandom_range(0, 11);
      start         <= 1'b0;
      epoch_seconds <= ec2c_pkg::EPOCH_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every pending date arrive and the block go idle
  task automatic wait_idle();
    start <= 1'b0;
    // let a transfer at the current edge show as busy before polling
    @(posedge clk);
    while (pending_dates.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_zone(input logic [ec2c_pkg::ZONE_W-1:0] zone);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= zone;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= ec2c_pkg::ZONE_W'($urandom);
  endtask

  // second count for a local time near the start or end of a month
  function automatic logic [ec2c_pkg::EPOCH_W-1:0] near_month_edge(
      input logic [ec2c_pkg::ZONE_W-1:0] zone);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned yy;
    int unsigned mm;
    longint      day_index;
    longint      t;
    y = $urandom_range(FIRST_YEAR, LAST_YEAR);
    m = $urandom_range(0, 11);
    d = $urandom_range(0, 1) ? 1 : days_in_month(m, y);
    day_index = d - 1;
    for (yy = FIRST_YEAR; yy < y; yy++) day_index += 365 + is_leap_year(yy);
    for (mm = 0; mm < m; mm++) day_index += days_in_month(mm, y);
    t = day_index * SECS_DAY - longint'(zone) * SECS_HOUR;
    // mostly hug midnight, sometimes any time on that day
    if ($urandom_range(0, 3) == 0) t += $urandom_range(0, SECS_DAY - 1);
    else if (d == 1) t += $urandom_range(0, 2);
    else t += SECS_DAY - 1 - $urandom_range(0, 2);
    if (t < 0) t = 0;
    if (t > EPOCH_MAX) t = EPOCH_MAX;
    return t[ec2c_pkg::EPOCH_W-1:0];
  endfunction

  // reset offset, field extremes and leap days
  task automatic test_reset_zone_directed();
    send_seconds(31'd0);
    send_seconds(31'h7FFFFFFF);
    send_seconds(31'd59);
    send_seconds(31'd60);
    send_seconds(31'd3599);
    send_seconds(31'd57599);
    send_seconds(31'd57600);
    send_seconds(31'd68169600);
    send_seconds(31'd946684799);
    send_seconds(31'd951782400);
    send_seconds(31'd951868800);
    send_seconds(31'd1078012800);
    send_seconds(31'h2AAAAAAA);
    send_seconds(31'h55555555);
  endtask

  // zero, top of range and fifteen for the offset
  task automatic test_zone_extremes();
    write_zone(4'd0);
    send_seconds(31'd0);
    send_seconds(31'd86399);
    send_seconds(31'd946684799);
    send_seconds(31'h7FFFFFFF);
    write_zone(4'd14);
    send_seconds(31'd35999);
    send_seconds(31'h7FFFFFFF);
    write_zone(4'd15);
    send_seconds(31'd0);
    send_seconds(31'd32399);
    send_seconds(31'd951749999);
    send_seconds(31'h7FFFFFFF);
  endtask

  // random counts over the whole range
  task automatic test_uniform_random(input logic [ec2c_pkg::ZONE_W-1:0] zone,
                                     input bit with_gaps);
    write_zone(zone);
    gaps_enabled = with_gaps;
    repeat (PHASE_ITEMS) send_seconds(ec2c_pkg::EPOCH_W'($urandom));
    gaps_enabled = 1'b1;
  endtask

  // counts that fall next to day, month and year boundaries
  task automatic test_calendar_boundaries(input logic [ec2c_pkg::ZONE_W-1:0] zone);
    write_zone(zone);
    repeat (PHASE_ITEMS) send_seconds(near_month_edge(zone));
  endtask

  // stimulus sequence
  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    epoch_seconds = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    mismatches    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    gaps_enabled  = 1'b1;
    zone_model    = ec2c_pkg::ZONE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_zone_directed();
    test_zone_extremes();
    test_uniform_random(4'd8, 1'b0);
    test_calendar_boundaries(4'd0);
    test_uniform_random(4'd15, 1'b1);
    test_calendar_boundaries(4'd14);
    test_uniform_random(ec2c_pkg::ZONE_W'($urandom_range(0, 15)), 1'b1);
    test_calendar_boundaries(ec2c_pkg::ZONE_W'($urandom_range(0, 15)));
    test_uniform_random(ec2c_pkg::ZONE_W'($urandom_range(1, 7)), 1'b1);
    test_calendar_boundaries(4'd15);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_dates.size() != 0)
        $error("%0d dates still pending at the end", pending_dates.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
